[src/ghp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ghp_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_STEP = 2'd2;
    localparam logic [1:0] REG_EXCL = 2'd3;

    localparam logic [8:0] DIM_MAX  = 9'd256;
    localparam logic [4:0] STEP_MAX = 5'd16;

    localparam logic signed [31:0] SENTINEL = 32'sd100000000;

    typedef struct packed {
        logic is_drain;
        logic is_sentinel;
    } t_req_ctl;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic       point_valid;
        logic [7:0] x_index;
        logic [7:0] y_index;
        t_rgb       rgb;
        logic       scan_done;
    } t_result;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SYNC_Y,
        BK_SYNC_X,
        BK_READ,
        BK_CHECK,
        BK_COLOR,
        BK_EMIT
    } t_back_state;

    typedef enum logic [2:0] {
        CL_IDLE,
        CL_SECTOR,
        CL_FLIP,
        CL_SCALE,
        CL_FRAC,
        CL_DONE
    } t_color_state;

endpackage

`default_nettype wire

[src/ghp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ghp_front #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    output logic                              o_full,
    input  wire logic                         i_req_type,
    input  wire logic signed [VALUE_BITS-1:0] i_cell_value,
    input  wire logic                         i_exclude,
    output logic                              o_valid,
    output ghp_pkg::t_req_ctl                 o_ctl,
    output logic signed [VALUE_BITS-1:0]      o_value,
    input  wire logic                         i_pop
);

    ghp_pkg::t_req_ctl             r_ctl [2];
    logic signed [VALUE_BITS-1:0]  r_val [2];
    logic                          r_wp;
    logic                          r_rp;
    logic [1:0]                    r_cnt;
    logic                          w_wr;
    logic                          w_rd;
    ghp_pkg::t_req_ctl             w_ctl;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    // classify the word on entry
    always_comb begin
        w_ctl.is_drain    = i_req_type;
        w_ctl.is_sentinel = i_exclude && (32'(i_cell_value) == ghp_pkg::SENTINEL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_ctl[r_wp] <= w_ctl;
            r_val[r_wp] <= i_cell_value;
        end
    end

    assign o_ctl   = r_ctl[r_rp];
    assign o_value = r_val[r_rp];

endmodule

`default_nettype wire

[src/ghp_color.sv]
`timescale 1ns / 1ps
`default_nettype none

module ghp_color #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    input  wire logic signed [VALUE_BITS-1:0] i_max,
    output logic                              o_done,
    output ghp_pkg::t_rgb                     o_rgb
);

    localparam int TW = VALUE_BITS + 3;
    localparam int NW = VALUE_BITS + 10;

    localparam logic [2:0] HUE_RED_UP    = 3'd0;
    localparam logic [2:0] HUE_GREEN_DN  = 3'd1;
    localparam logic [2:0] HUE_GREEN_UP  = 3'd2;
    localparam logic [2:0] HUE_BLUE_DN   = 3'd3;
    localparam logic [2:0] HUE_VIOLET_UP = 3'd4;
    localparam logic [2:0] HUE_BLACK     = 3'd5;

    ghp_pkg::t_color_state r_state;
    ghp_pkg::t_color_state n_state;

    logic [TW-1:0]         r_t;
    logic [TW-1:0]         r_dsh;
    logic [VALUE_BITS-1:0] r_d;
    logic [NW-1:0]         r_num;
    logic [NW-1:0]         r_dsh2;
    logic [2:0]            r_sector;
    logic [7:0]            r_frac;
    logic [3:0]            r_cnt;

    logic                  w_above;
    logic                  w_max_zero;
    logic [VALUE_BITS-1:0] w_diff;
    logic [TW-1:0]         w_t_in;
    logic [VALUE_BITS-1:0] w_d_in;
    logic                  w_ge;
    logic                  w_ge2;
    logic [VALUE_BITS-1:0] w_rsel;

    assign w_above    = (i_value > i_max);
    assign w_max_zero = (i_max == '0);
    assign w_diff     = VALUE_BITS'(i_max - i_value);
    assign w_t_in     = w_max_zero ? TW'(9) : ((TW'(w_diff) << 3) + TW'(w_diff));
    assign w_d_in     = w_max_zero ? VALUE_BITS'(2) : {i_max[VALUE_BITS-2:0], 1'b0};
    assign w_ge       = (r_t >= r_dsh);
    assign w_ge2      = (r_num >= r_dsh2);
    assign w_rsel     = VALUE_BITS'(r_t);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ghp_pkg::CL_IDLE: begin
                if (i_start) begin
                    n_state = w_above ? ghp_pkg::CL_DONE : ghp_pkg::CL_SECTOR;
                end
            end
            ghp_pkg::CL_SECTOR: begin
                if (r_cnt == 4'd1) begin
                    n_state = ghp_pkg::CL_FLIP;
                end
            end
            ghp_pkg::CL_FLIP:  n_state = ghp_pkg::CL_SCALE;
            ghp_pkg::CL_SCALE: n_state = ghp_pkg::CL_FRAC;
            ghp_pkg::CL_FRAC: begin
                if (r_cnt == 4'd1) begin
                    n_state = ghp_pkg::CL_DONE;
                end
            end
            ghp_pkg::CL_DONE:  n_state = ghp_pkg::CL_IDLE;
            default:           n_state = ghp_pkg::CL_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == ghp_pkg::CL_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ghp_pkg::CL_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ghp_pkg::CL_IDLE: begin
                r_t      <= w_t_in;
                r_d      <= w_d_in;
                r_dsh    <= TW'(w_d_in) << 2;
                r_cnt    <= 4'd3;
                r_frac   <= 8'd0;
                r_sector <= w_above ? HUE_BLACK : HUE_RED_UP;
            end
            ghp_pkg::CL_SECTOR: begin
                if (w_ge) begin
                    r_t <= r_t - r_dsh;
                end
                r_sector <= {r_sector[1:0], w_ge};
                r_dsh    <= r_dsh >> 1;
                r_cnt    <= r_cnt - 4'd1;
            end
            ghp_pkg::CL_FLIP: begin
                // odd sectors ramp down
                if (r_sector[0]) begin
                    r_t <= TW'(r_d) - r_t;
                end
            end
            ghp_pkg::CL_SCALE: begin
                // 510*f + d over 2d gives the rounded channel
                r_num  <= (NW'(w_rsel) << 9) - (NW'(w_rsel) << 1) + NW'(r_d);
                r_dsh2 <= NW'(r_d) << 8;
                r_cnt  <= 4'd8;
            end
            ghp_pkg::CL_FRAC: begin
                if (w_ge2) begin
                    r_num <= r_num - r_dsh2;
                end
                r_frac <= {r_frac[6:0], w_ge2};
                r_dsh2 <= r_dsh2 >> 1;
                r_cnt  <= r_cnt - 4'd1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    always_comb begin
        case (r_sector)
            HUE_RED_UP:    o_rgb = '{red: 8'd255,  green: r_frac, blue: 8'd0};
            HUE_GREEN_DN:  o_rgb = '{red: r_frac, green: 8'd255,  blue: 8'd0};
            HUE_GREEN_UP:  o_rgb = '{red: 8'd0,    green: 8'd255, blue: r_frac};
            HUE_BLUE_DN:   o_rgb = '{red: 8'd0,    green: r_frac, blue: 8'd255};
            HUE_VIOLET_UP: o_rgb = '{red: r_frac, green: 8'd0,    blue: 8'd255};
            default:       o_rgb = '{red: 8'd0,    green: 8'd0,   blue: 8'd0};
        endcase
    end

endmodule

`default_nettype wire

[src/ghp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module ghp_back #(
    parameter int MAX_CELLS  = 65536,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_req_valid,
    input  wire ghp_pkg::t_req_ctl            i_req_ctl,
    input  wire logic signed [VALUE_BITS-1:0] i_req_value,
    output logic                              o_req_pop,
    input  wire logic [8:0]                   i_rows,
    input  wire logic [8:0]                   i_cols,
    input  wire logic [4:0]                   i_step,
    input  wire logic                         i_exclude,
    output logic                              o_res_push,
    output ghp_pkg::t_result                  o_res,
    input  wire logic                         i_res_full
);

    localparam int AW  = $clog2(MAX_CELLS);
    localparam int IW  = $clog2(MAX_CELLS) + 1;
    localparam int PW  = (IW > 18) ? IW : 18;
    localparam int CNT = (IW > 8) ? IW : 8;
    localparam int CW  = $clog2(CNT + 1);

    ghp_pkg::t_back_state r_state;
    ghp_pkg::t_back_state n_state;

    logic signed [VALUE_BITS-1:0] r_mem [MAX_CELLS];
    logic signed [VALUE_BITS-1:0] r_rd_data;

    logic signed [VALUE_BITS-1:0] r_max;
    logic [IW-1:0]                r_load_idx;
    logic [IW-1:0]                r_scan_idx;
    logic                         r_pos_ok;
    logic [8:0]                   r_rows_sync;
    logic [4:0]                   r_step_sync;
    logic [7:0]                   r_x;
    logic [7:0]                   r_y;
    logic [3:0]                   r_xm;
    logic [3:0]                   r_ym;
    logic [7:0]                   r_px;
    logic [7:0]                   r_py;
    logic [IW-1:0]                r_idx_sh;
    logic [7:0]                   r_xsh;
    logic [CW-1:0]                r_cnt;
    ghp_pkg::t_result             r_result;

    logic [17:0]   w_prod;
    logic [IW-1:0] w_size;
    logic [IW-1:0] w_limit;
    logic          w_at_end;
    logic          w_need_sync;
    logic          w_load_ok;
    logic          w_mem_we;
    logic          w_is_drain;
    logic          w_cell_sent;
    logic          w_keep;
    logic          w_bit;
    logic [8:0]    w_rem2;
    logic          w_q;
    logic [7:0]    w_rem_n;
    logic [4:0]    w_ym2;
    logic [3:0]    w_ym_n;
    logic [4:0]    w_xm2;
    logic [3:0]    w_xm_n;
    logic [8:0]    w_x_inc;
    logic [4:0]    w_xm_inc;
    logic [4:0]    w_ym_inc;
    logic          w_color_start;
    logic          w_color_done;
    ghp_pkg::t_rgb w_rgb;

    // grid size, cut to the store depth
    assign w_prod = {9'd0, i_rows} * {9'd0, i_cols};
    assign w_size = (PW'(w_prod) > PW'(MAX_CELLS)) ? IW'(MAX_CELLS) : IW'(w_prod);

    assign w_limit     = (r_load_idx < w_size) ? r_load_idx : w_size;
    assign w_at_end    = (r_scan_idx >= w_limit);
    assign w_need_sync = !r_pos_ok || (i_rows != r_rows_sync) || (i_step != r_step_sync);
    assign w_load_ok   = (r_load_idx < w_size);
    assign w_is_drain  = i_req_ctl.is_drain;

    assign w_cell_sent = i_exclude && (32'(r_rd_data) == ghp_pkg::SENTINEL);
    assign w_keep      = !r_rd_data[VALUE_BITS-1] && !w_cell_sent
                         && (r_xm == 4'd0) && (r_ym == 4'd0);

    // one quotient bit of index / rows per cycle, y mod step tracked alongside
    assign w_bit   = r_idx_sh[IW-1];
    assign w_rem2  = {r_x, w_bit};
    assign w_q     = (w_rem2 >= i_rows);
    assign w_rem_n = w_q ? 8'(w_rem2 - i_rows) : 8'(w_rem2);
    assign w_ym2   = {r_ym, w_q};
    assign w_ym_n  = (w_ym2 >= i_step) ? 4'(w_ym2 - i_step) : 4'(w_ym2);
    assign w_xm2   = {r_xm, r_xsh[7]};
    assign w_xm_n  = (w_xm2 >= i_step) ? 4'(w_xm2 - i_step) : 4'(w_xm2);

    assign w_x_inc  = {1'b0, r_x} + 9'd1;
    assign w_xm_inc = {1'b0, r_xm} + 5'd1;
    assign w_ym_inc = {1'b0, r_ym} + 5'd1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ghp_pkg::BK_IDLE: begin
                if (i_req_valid && w_is_drain) begin
                    n_state = w_need_sync ? ghp_pkg::BK_SYNC_Y : ghp_pkg::BK_READ;
                end
            end
            ghp_pkg::BK_SYNC_Y: begin
                if (r_cnt == CW'(1)) begin
                    n_state = ghp_pkg::BK_SYNC_X;
                end
            end
            ghp_pkg::BK_SYNC_X: begin
                if (r_cnt == CW'(1)) begin
                    n_state = ghp_pkg::BK_READ;
                end
            end
            ghp_pkg::BK_READ: begin
                n_state = w_at_end ? ghp_pkg::BK_EMIT : ghp_pkg::BK_CHECK;
            end
            ghp_pkg::BK_CHECK: begin
                n_state = w_keep ? ghp_pkg::BK_COLOR : ghp_pkg::BK_READ;
            end
            ghp_pkg::BK_COLOR: begin
                if (w_color_done) begin
                    n_state = ghp_pkg::BK_EMIT;
                end
            end
            ghp_pkg::BK_EMIT: begin
                if (!i_res_full) begin
                    n_state = ghp_pkg::BK_IDLE;
                end
            end
            default: n_state = ghp_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_req_pop     = (r_state == ghp_pkg::BK_IDLE) && i_req_valid;
        w_mem_we      = o_req_pop && !w_is_drain && w_load_ok;
        w_color_start = (r_state == ghp_pkg::BK_CHECK) && w_keep;
        o_res_push    = (r_state == ghp_pkg::BK_EMIT) && !i_res_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ghp_pkg::BK_IDLE;
            r_max      <= '1;
            r_load_idx <= '0;
            r_scan_idx <= '0;
            r_pos_ok   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_mem_we) begin
                r_load_idx <= r_load_idx + IW'(1);
                if (!i_req_ctl.is_sentinel && (i_req_value > r_max)) begin
                    r_max <= i_req_value;
                end
            end
            if (r_state == ghp_pkg::BK_CHECK) begin
                r_scan_idx <= r_scan_idx + IW'(1);
            end
            if ((r_state == ghp_pkg::BK_SYNC_X) && (r_cnt == CW'(1))) begin
                r_pos_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_load_idx[AW-1:0]] <= i_req_value;
        end
        r_rd_data <= r_mem[r_scan_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ghp_pkg::BK_IDLE: begin
                r_idx_sh <= r_scan_idx;
                r_cnt    <= CW'(IW);
                if (i_req_valid && w_is_drain && w_need_sync) begin
                    r_x  <= 8'd0;
                    r_y  <= 8'd0;
                    r_ym <= 4'd0;
                end
            end
            ghp_pkg::BK_SYNC_Y: begin
                r_idx_sh <= r_idx_sh << 1;
                r_x      <= w_rem_n;
                r_y      <= {r_y[6:0], w_q};
                r_ym     <= w_ym_n;
                if (r_cnt == CW'(1)) begin
                    r_xsh <= w_rem_n;
                    r_xm  <= 4'd0;
                    r_cnt <= CW'(8);
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
            ghp_pkg::BK_SYNC_X: begin
                r_xsh       <= r_xsh << 1;
                r_xm        <= w_xm_n;
                r_cnt       <= r_cnt - CW'(1);
                r_rows_sync <= i_rows;
                r_step_sync <= i_step;
            end
            ghp_pkg::BK_READ: begin
                if (w_at_end) begin
                    r_result <= '{point_valid: 1'b0, x_index: 8'd0, y_index: 8'd0,
                                  rgb: '0, scan_done: 1'b1};
                end
            end
            ghp_pkg::BK_CHECK: begin
                r_px <= r_x;
                r_py <= r_y;
                // advance the position of the scan pointer
                if (w_x_inc == i_rows) begin
                    r_x  <= 8'd0;
                    r_xm <= 4'd0;
                    r_y  <= r_y + 8'd1;
                    r_ym <= (w_ym_inc == i_step) ? 4'd0 : 4'(w_ym_inc);
                end else begin
                    r_x  <= 8'(w_x_inc);
                    r_xm <= (w_xm_inc == i_step) ? 4'd0 : 4'(w_xm_inc);
                end
            end
            ghp_pkg::BK_COLOR: begin
                if (w_color_done) begin
                    r_result <= '{point_valid: 1'b1, x_index: r_px, y_index: r_py,
                                  rgb: w_rgb, scan_done: 1'b0};
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    ghp_color #(
        .VALUE_BITS(VALUE_BITS)
    ) u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_color_start),
        .i_value (r_rd_data),
        .i_max   (r_max),
        .o_done  (w_color_done),
        .o_rgb   (w_rgb)
    );

    assign o_res = r_result;

endmodule

`default_nettype wire

[src/ghp_outq.sv]
`timescale 1ns / 1ps
`default_nettype none

module ghp_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ghp_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_empty,
    output ghp_pkg::t_result      o_data,
    input  wire logic             i_pop
);

    ghp_pkg::t_result r_buf [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_buf[r_wp] <= i_data;
        end
    end

    assign o_data = r_buf[r_rp];

endmodule

`default_nettype wire

[src/grid_heatmap_pseudocolor_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                        Word
// request   in         push / full                      i_req_type, i_cell_value
// result    out        empty / pop                      o_point_valid, o_x_index, o_y_index,
//                                                       o_red, o_green, o_blue, o_scan_done
// config    in         psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// A drain reads the store, then tests, for each cell scanned, and runs the colour
// divider once a kept cell is found. The first drain after reset, or after grid_rows
// or decimation_step changed, first rebuilds x, y from the scan index.
// Reset is synchronous; the store is not cleared, as the scan never passes the load count.
// Two-word queues on both sides let input and output stall independently of the engine.

module grid_heatmap_pseudocolor_top #(
    parameter int MAX_CELLS  = 65536,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         i_req_type,
    input  wire logic signed [VALUE_BITS-1:0] i_cell_value,
    output logic                              empty,
    input  wire logic                         pop,
    output logic                              o_point_valid,
    output logic [7:0]                        o_x_index,
    output logic [7:0]                        o_y_index,
    output logic [7:0]                        o_red,
    output logic [7:0]                        o_green,
    output logic [7:0]                        o_blue,
    output logic                              o_scan_done,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [3:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [8:0] r_rows;
    logic [8:0] r_cols;
    logic [4:0] r_step;
    logic       r_excl;

    logic [8:0] w_rows_c;
    logic [8:0] w_cols_c;
    logic [4:0] w_step_c;
    logic       w_cfg_wr;

    logic                         w_req_valid;
    ghp_pkg::t_req_ctl            w_req_ctl;
    logic signed [VALUE_BITS-1:0] w_req_value;
    logic                         w_req_pop;
    logic                         w_res_push;
    ghp_pkg::t_result             w_res;
    logic                         w_res_full;
    ghp_pkg::t_result             w_head;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ghp_pkg::DIM_MAX;
            r_cols <= ghp_pkg::DIM_MAX;
            r_step <= 5'd1;
            r_excl <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                ghp_pkg::REG_ROWS: r_rows <= pwdata[8:0];
                ghp_pkg::REG_COLS: r_cols <= pwdata[8:0];
                ghp_pkg::REG_STEP: r_step <= pwdata[4:0];
                ghp_pkg::REG_EXCL: r_excl <= pwdata[0];
                default:           r_excl <= r_excl;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ghp_pkg::REG_ROWS: prdata = 32'(r_rows);
            ghp_pkg::REG_COLS: prdata = 32'(r_cols);
            ghp_pkg::REG_STEP: prdata = 32'(r_step);
            ghp_pkg::REG_EXCL: prdata = 32'(r_excl);
            default:           prdata = 32'd0;
        endcase
    end

    // zero acts as one, anything above the limit as the limit
    assign w_rows_c = (r_rows == 9'd0) ? 9'd1 :
                      ((r_rows > ghp_pkg::DIM_MAX) ? ghp_pkg::DIM_MAX : r_rows);
    assign w_cols_c = (r_cols == 9'd0) ? 9'd1 :
                      ((r_cols > ghp_pkg::DIM_MAX) ? ghp_pkg::DIM_MAX : r_cols);
    assign w_step_c = (r_step == 5'd0) ? 5'd1 :
                      ((r_step > ghp_pkg::STEP_MAX) ? ghp_pkg::STEP_MAX : r_step);

    ghp_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_req_type   (i_req_type),
        .i_cell_value (i_cell_value),
        .i_exclude    (r_excl),
        .o_valid      (w_req_valid),
        .o_ctl        (w_req_ctl),
        .o_value      (w_req_value),
        .i_pop        (w_req_pop)
    );

    ghp_back #(
        .MAX_CELLS  (MAX_CELLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req_ctl   (w_req_ctl),
        .i_req_value (w_req_value),
        .o_req_pop   (w_req_pop),
        .i_rows      (w_rows_c),
        .i_cols      (w_cols_c),
        .i_step      (w_step_c),
        .i_exclude   (r_excl),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    ghp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .o_data  (w_head),
        .i_pop   (pop)
    );

    assign o_point_valid = w_head.point_valid;
    assign o_x_index     = w_head.x_index;
    assign o_y_index     = w_head.y_index;
    assign o_red         = w_head.rgb.red;
    assign o_green       = w_head.rgb.green;
    assign o_blue        = w_head.rgb.blue;
    assign o_scan_done   = w_head.scan_done;

endmodule

`default_nettype wire

[src/ghp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ghp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic       o_point_valid,
    input wire logic [7:0] o_x_index,
    input wire logic [7:0] o_y_index,
    input wire logic [7:0] o_red,
    input wire logic [7:0] o_green,
    input wire logic [7:0] o_blue,
    input wire logic       o_scan_done
);

    // every word is either a point or the end marker, never both
    a_kind_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_point_valid != o_scan_done))
        else $error("result word is neither or both of point and end marker");

    // the end marker carries an all-zero payload
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_scan_done) |-> (o_x_index == 8'd0 && o_y_index == 8'd0 &&
                                     o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0))
        else $error("end marker with nonzero payload");

    // a point that is not black has full value: one channel at 255
    a_full_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_point_valid && (o_red != 8'd0 || o_green != 8'd0 || o_blue != 8'd0))
        |-> (o_red == 8'd255 || o_green == 8'd255 || o_blue == 8'd255))
        else $error("colored point without a saturated channel");

    // a waiting word holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_point_valid) && $stable(o_x_index) &&
                              $stable(o_y_index) && $stable(o_red) && $stable(o_green) &&
                              $stable(o_blue) && $stable(o_scan_done)))
        else $error("result word changed while stalled");

    // after reset the output queue is empty and the input queue is not full
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule

bind grid_heatmap_pseudocolor_top ghp_checker u_ghp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_point_valid (o_point_valid),
    .o_x_index     (o_x_index),
    .o_y_index     (o_y_index),
    .o_red         (o_red),
    .o_green       (o_green),
    .o_blue        (o_blue),
    .o_scan_done   (o_scan_done)
);

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int          STORE_DEPTH = 65536;
    localparam int          QUIET_LIMIT = 20000;
    localparam int          SETTLE      = 40;
    localparam int unsigned INT_TOP     = 32'h7FFF_FFFF;

    typedef struct {
        bit          drain;
        int          value;
        bit          hold;
        int unsigned gap;
    } t_cell_request;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic        i_req_type   = 1'b0;
    logic [31:0] i_cell_value = '0;
    logic        empty;
    logic        pop          = 1'b0;
    logic        o_point_valid;
    logic [7:0]  o_x_index;
    logic [7:0]  o_y_index;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        o_scan_done;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    grid_heatmap_pseudocolor_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_req_type    (i_req_type),
        .i_cell_value  (i_cell_value),
        .empty         (empty),
        .pop           (pop),
        .o_point_valid (o_point_valid),
        .o_x_index     (o_x_index),
        .o_y_index     (o_y_index),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_scan_done   (o_scan_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // shadow of the heat map state
    int          cell_mem [STORE_DEPTH];
    int          peak_value;
    int unsigned load_count;
    int unsigned scan_pos;
    logic [8:0]  cfg_rows;
    logic [8:0]  cfg_cols;
    logic [4:0]  cfg_step;
    logic        cfg_excl;

    t_cell_request    cell_requests [$];
    ghp_pkg::t_result pending_points [$];
    t_cell_request    next_req;

    bit          req_taken    = 1'b0;
    bit          word_taken   = 1'b0;
    int unsigned send_wait    = 0;
    int unsigned pop_wait     = 0;
    int unsigned send_burst   = 0;
    int unsigned pop_burst    = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatch_count = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned grid_cells();
        int unsigned n;
        n = clamp_to(32'(cfg_rows), 256) * clamp_to(32'(cfg_cols), 256);
        if (n > STORE_DEPTH) n = STORE_DEPTH;
        return n;
    endfunction

    function automatic bit is_excluded(int v);
        return cfg_excl && v == int'(ghp_pkg::SENTINEL);
    endfunction

    function automatic ghp_pkg::t_rgb hue_ramp(int v, int mx);
        longint unsigned num, den, sector, rem, ch;
        ghp_pkg::t_rgb c;
        c = '0;
        if (v > mx) return c;
        if (mx == 0) begin
            num = 9;
            den = 2;
        end else begin
            num = 9 * longint'(longint'(mx) - longint'(v));
            den = 2 * longint'(mx);
        end
        sector = num / den;
        rem    = num % den;
        if (sector[0]) rem = den - rem;
        ch = (510 * rem + den) / (2 * den);
        case (sector)
            0: c = '{8'd255, ch[7:0], 8'd0};
            1: c = '{ch[7:0], 8'd255, 8'd0};
            2: c = '{8'd0, 8'd255, ch[7:0]};
            3: c = '{8'd0, ch[7:0], 8'd255};
            4: c = '{ch[7:0], 8'd0, 8'd255};
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic void store_cell(int v);
        if (load_count < grid_cells()) begin
            cell_mem[load_count] = v;
            if (!is_excluded(v) && v > peak_value) peak_value = v;
            load_count++;
        end
    endfunction

    // advance the scan to the next kept cell and color it, or give the end marker if none is left
    function automatic ghp_pkg::t_result next_kept_point();
        ghp_pkg::t_result r;
        int unsigned rows, step, lim, idx, xi, yi;
        int          v;
        r    = '0;
        rows = clamp_to(32'(cfg_rows), 256);
        step = clamp_to(32'(cfg_step), 16);
        lim  = (load_count < grid_cells()) ? load_count : grid_cells();
        while (scan_pos < lim) begin
            idx = scan_pos;
            v   = cell_mem[idx];
            xi  = idx % rows;
            yi  = idx / rows;
            scan_pos++;
            if (v < 0 || is_excluded(v)) continue;
            if ((xi % step) != 0 || (yi % step) != 0) continue;
            r.point_valid = 1'b1;
            r.x_index     = xi[7:0];
            r.y_index     = yi[7:0];
            r.rgb         = hue_ramp(v, peak_value);
            return r;
        end
        r.scan_done = 1'b1;
        return r;
    endfunction

    function automatic int unsigned draw_wait(inout int unsigned burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            burst = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic int pick_value(int unsigned top);
        case ($urandom_range(0, 9))
            0: return int'($urandom | 32'h8000_0000);
            1: return (cfg_excl || top >= int'(ghp_pkg::SENTINEL)) ?
                      int'(ghp_pkg::SENTINEL) : 0;
            2: return 0;
            3: return int'(top);
            default: return int'($urandom_range(0, top));
        endcase
    endfunction

    task automatic queue_word(bit drain, int value, bit hold);
        t_cell_request w;
        w.drain = drain;
        w.value = drain ? int'($urandom) : value;
        w.hold  = hold;
        w.gap   = draw_wait(send_burst);
        cell_requests.insert(cell_requests.size(), w);
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ghp_pkg::REG_ROWS: cfg_rows = value[8:0];
            ghp_pkg::REG_COLS: cfg_cols = value[8:0];
            ghp_pkg::REG_STEP: cfg_step = value[4:0];
            ghp_pkg::REG_EXCL: cfg_excl = value[0];
            default: ;
        endcase
    endtask

    // hold until every queued word is sent and every point came back
    task automatic wait_idle();
        @(posedge i_clk);
        while (cell_requests.size() != 0 || push || pending_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [31:0] rows, logic [31:0] cols, logic [31:0] step,
                             logic [31:0] excl, int unsigned top, int count,
                             int unsigned drain_pct);
        write_reg(ghp_pkg::REG_ROWS, rows);
        write_reg(ghp_pkg::REG_COLS, cols);
        write_reg(ghp_pkg::REG_STEP, step);
        write_reg(ghp_pkg::REG_EXCL, excl);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < drain_pct)
                queue_word(1'b1, 0, $urandom_range(0, 59) == 0);
            else
                queue_word(1'b0, pick_value(top), $urandom_range(0, 59) == 0);
        end
        wait_idle();
    endtask

    // request side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && !req_taken)) begin
            if (send_wait > 0) begin
                send_wait--;
                push <= 1'b0;
            end else if (cell_requests.size() > 0 &&
                         !(cell_requests[0].hold && pending_points.size() > 0)) begin
                next_req = cell_requests.pop_front();
                push         <= 1'b1;
                i_req_type   <= next_req.drain;
                i_cell_value <= next_req.value;
                send_wait    = next_req.gap;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (!(pop && !word_taken)) begin
            if (pop_wait > 0) begin
                pop_wait--;
                pop <= 1'b0;
            end else begin
                pop      <= 1'b1;
                pop_wait = draw_wait(pop_burst);
            end
        end
    end

    always @(posedge i_clk) begin
        ghp_pkg::t_result want;
        if (!i_rst_n) begin
            req_taken    <= 1'b0;
            word_taken   <= 1'b0;
            quiet_cycles = 0;
        end else begin
            req_taken  <= push && !full;
            word_taken <= pop && !empty;
            if (push && !full) begin
                if (i_req_type)
                    pending_points.insert(pending_points.size(), next_kept_point());
                else
                    store_cell(int'(i_cell_value));
            end
            if (pop && !empty) begin
                if (pending_points.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: x %0d y %0d done %0b",
                                 o_x_index, o_y_index, o_scan_done);
                end else begin
                    want = pending_points.pop_front();
                    check_field("point_valid", 8'(want.point_valid), 8'(o_point_valid));
                    check_field("x_index", want.x_index, o_x_index);
                    check_field("y_index", want.y_index, o_y_index);
                    check_field("red", want.rgb.red, o_red);
                    check_field("green", want.rgb.green, o_green);
                    check_field("blue", want.rgb.blue, o_blue);
                    check_field("scan_done", 8'(want.scan_done), 8'(o_scan_done));
                end
            end
            if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        peak_value = -1;
        load_count = 0;
        scan_pos   = 0;
        cfg_rows   = 9'd256;
        cfg_cols   = 9'd256;
        cfg_step   = 5'd1;
        cfg_excl   = 1'b0;
        i_rst_n    = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty store, zero maximum, unreached cells
        queue_word(1'b1, 0, 1'b0);
        queue_word(1'b0, 0, 1'b0);
        queue_word(1'b0, 0, 1'b0);
        queue_word(1'b1, 0, 1'b0);
        queue_word(1'b1, 0, 1'b0);
        queue_word(1'b1, 0, 1'b0);
        queue_word(1'b0, -1, 1'b0);
        queue_word(1'b0, int'(32'h8000_0000), 1'b0);
        queue_word(1'b1, 0, 1'b0);
        wait_idle();

        // sentinel kept out of the maximum, then shown above it
        write_reg(ghp_pkg::REG_EXCL, 32'd1);
        queue_word(1'b0, int'(ghp_pkg::SENTINEL), 1'b0);
        wait_idle();
        write_reg(ghp_pkg::REG_EXCL, 32'd0);
        queue_word(1'b1, 0, 1'b0);
        queue_word(1'b0, int'(INT_TOP), 1'b0);
        queue_word(1'b0, 1, 1'b0);
        queue_word(1'b0, int'(INT_TOP - 1), 1'b0);
        queue_word(1'b0, 1073741823, 1'b0);
        queue_word(1'b0, int'(ghp_pkg::SENTINEL), 1'b1);
        repeat (6) queue_word(1'b1, 0, 1'b0);
        wait_idle();

        // rows, cols, step, excl, value ceiling, words, drain percent
        run_phase(32'd0,   32'd256, 32'd1,  32'd1, 20,         60,  40);
        run_phase(32'd7,   32'd200, 32'd2,  32'd0, 1000,       80,  40);
        run_phase(32'd1,   32'd1,   32'd0,  32'd1, 1000,       20,  50);
        run_phase(32'd2,   32'd256, 32'd31, 32'd1, 100000,     80,  25);
        run_phase(32'd256, 32'd0,   32'd3,  32'd0, 200000000,  80,  40);
        run_phase(32'd13,  32'd255, 32'd16, 32'd1, INT_TOP,    120, 40);
        run_phase(32'd511, 32'd511, 32'd1,  32'd0, INT_TOP,    130, 40);

        if (mismatch_count == 0 && pending_points.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
